FILE: rtl/core/imubc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package imubc_pkg;

  localparam int NAXES = 6;
  localparam int NGYRO = 3;

  // axis order: accel x, y, z, then gyro x, y, z
  localparam int AXIS_ACCEL_X = 0;
  localparam int AXIS_ACCEL_Y = 1;
  localparam int AXIS_ACCEL_Z = 2;
  localparam int AXIS_GYRO_X  = 3;
  localparam int AXIS_GYRO_Y  = 4;
  localparam int AXIS_GYRO_Z  = 5;

  localparam int RAW_W      = 16;
  localparam int FRAC_SHIFT = 8;
  localparam int SUM_W      = 24;
  localparam int OFF_W      = 24;
  localparam int ACC_W      = RAW_W + FRAC_SHIFT + 1;
  localparam int GYR_W      = 18;

  // offset divide: |sum| * 256 stays below 2^32, so a 33-bit reciprocal is exact
  localparam int OFF_DIVIDEND_W = 32;
  localparam int OFF_RECIP_W    = 33;

  // gyro divide by 131: |diff| < 2^25, reciprocal ceil(2^33 / 131) is exact
  localparam int                      GYRO_DIV     = 131;
  localparam int                      GYRO_RECIP_W = 26;
  localparam logic [GYRO_RECIP_W-1:0] GYRO_RECIP   = 26'd65572020;
  localparam int                      GYRO_SHIFT   = 33;
  localparam int                      GYRO_PROD_W  = ACC_W + GYRO_RECIP_W;

  typedef logic signed [RAW_W-1:0] raw_t;
  typedef logic signed [OFF_W-1:0] off_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic signed [ACC_W-1:0] diff_t;
  typedef logic signed [GYR_W-1:0] gyro_t;

  typedef struct packed {
    logic accept;   // item taken at the input this cycle
    logic cal;      // that item is a calibration item
    logic adv_a;    // first stage moves on
    logic adv_b;    // second stage moves on
    logic done_b;   // item in the second stage closes a calibration
  } ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/imubc_sample_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface imubc_sample_if;
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  imubc_pkg::raw_t      raw_accel_x;
  imubc_pkg::raw_t      raw_accel_y;
  imubc_pkg::raw_t      raw_accel_z;
  imubc_pkg::raw_t      raw_gyro_x;
  imubc_pkg::raw_t      raw_gyro_y;
  imubc_pkg::raw_t      raw_gyro_z;

  modport source (
    output valid, req_type, raw_accel_x, raw_accel_y, raw_accel_z,
           raw_gyro_x, raw_gyro_y, raw_gyro_z,
    input  ready
  );

  modport sink (
    input  valid, req_type, raw_accel_x, raw_accel_y, raw_accel_z,
           raw_gyro_x, raw_gyro_y, raw_gyro_z,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/imubc_result_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface imubc_result_if;
  logic                 valid;
  logic                 ready;
  imubc_pkg::diff_t     accel_x_g;
  imubc_pkg::diff_t     accel_y_g;
  imubc_pkg::diff_t     accel_z_g;
  imubc_pkg::gyro_t     gyro_x_dps;
  imubc_pkg::gyro_t     gyro_y_dps;
  imubc_pkg::gyro_t     gyro_z_dps;
  logic                 cal_done;

  modport source (
    output valid, accel_x_g, accel_y_g, accel_z_g,
           gyro_x_dps, gyro_y_dps, gyro_z_dps, cal_done,
    input  ready
  );

  modport sink (
    input  valid, accel_x_g, accel_y_g, accel_z_g,
           gyro_x_dps, gyro_y_dps, gyro_z_dps, cal_done,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/imubc_offset_calc.sv
`timescale 1ns / 1ps
`default_nettype none

module imubc_offset_calc #(
  parameter int NUM_CAL_SAMPLES = 40
) (
  input  logic              clk,
  input  logic              rst,
  input  imubc_pkg::ctrl_t  ctrl,
  input  imubc_pkg::raw_t   raw [imubc_pkg::NAXES],
  output logic              done,
  output imubc_pkg::off_t   offsets [imubc_pkg::NAXES]
);

  localparam int CNT_W   = $clog2(NUM_CAL_SAMPLES + 1);
  localparam int LOG_N   = $clog2(NUM_CAL_SAMPLES);
  localparam int RECIP_K = imubc_pkg::OFF_DIVIDEND_W + LOG_N;
  localparam logic [63:0] RECIP_FULL =
      ((64'd1 << RECIP_K) + 64'(NUM_CAL_SAMPLES) - 64'd1) / 64'(NUM_CAL_SAMPLES);
  localparam logic [imubc_pkg::OFF_RECIP_W-1:0] RECIP =
      RECIP_FULL[imubc_pkg::OFF_RECIP_W-1:0];
  localparam int PROD_W  = imubc_pkg::SUM_W + imubc_pkg::OFF_RECIP_W;
  localparam int Q_SHIFT = RECIP_K - imubc_pkg::FRAC_SHIFT;

  logic [CNT_W-1:0]                  cnt;
  logic [CNT_W-1:0]                  cnt_inc;
  imubc_pkg::sum_t                   sums      [imubc_pkg::NAXES];
  imubc_pkg::sum_t                   sum_final [imubc_pkg::NAXES];
  imubc_pkg::sum_t                   sum_a     [imubc_pkg::NAXES];
  logic [imubc_pkg::SUM_W-1:0]       mag_a     [imubc_pkg::NAXES];
  logic [PROD_W-1:0]                 prod_b    [imubc_pkg::NAXES];
  logic                              sign_b    [imubc_pkg::NAXES];
  logic [imubc_pkg::OFF_W-1:0]       q_b       [imubc_pkg::NAXES];
  imubc_pkg::off_t                   off_next  [imubc_pkg::NAXES];

  always_comb begin
    cnt_inc = cnt + CNT_W'(1);
    done    = ctrl.cal && (cnt_inc == CNT_W'(NUM_CAL_SAMPLES));
    for (int i = 0; i < imubc_pkg::NAXES; i++) begin
      sum_final[i] = sums[i] + {{(imubc_pkg::SUM_W - imubc_pkg::RAW_W){raw[i][imubc_pkg::RAW_W-1]}},
                                raw[i]};
      // divide the magnitude so the quotient rounds toward zero
      mag_a[i]     = sum_a[i][imubc_pkg::SUM_W-1] ? ($unsigned(~sum_a[i]) + imubc_pkg::SUM_W'(1))
                                                  : $unsigned(sum_a[i]);
      q_b[i]       = prod_b[i][Q_SHIFT +: imubc_pkg::OFF_W];
      off_next[i]  = sign_b[i] ? $signed(~q_b[i] + imubc_pkg::OFF_W'(1)) : $signed(q_b[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      for (int i = 0; i < imubc_pkg::NAXES; i++) begin
        sums[i]    <= '0;
        offsets[i] <= '0;
      end
    end else begin
      if (ctrl.accept && ctrl.cal) begin
        cnt <= done ? '0 : cnt_inc;
        for (int i = 0; i < imubc_pkg::NAXES; i++) begin
          sums[i] <= done ? '0 : sum_final[i];
        end
      end
      if (ctrl.adv_b && ctrl.done_b) begin
        for (int i = 0; i < imubc_pkg::NAXES; i++) begin
          offsets[i] <= off_next[i];
        end
      end
    end
  end

  // capture the running sums of each item taken, then multiply by the reciprocal of the sample count
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      for (int i = 0; i < imubc_pkg::NAXES; i++) begin
        sum_a[i] <= sum_final[i];
      end
    end
    if (ctrl.adv_a) begin
      for (int i = 0; i < imubc_pkg::NAXES; i++) begin
        prod_b[i] <= PROD_W'(mag_a[i]) * PROD_W'(RECIP);
        sign_b[i] <= sum_a[i][imubc_pkg::SUM_W-1];
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_below_n: assert property (@(posedge clk) disable iff (rst)
    cnt < CNT_W'(NUM_CAL_SAMPLES))
    else $error("calibration count reached the sample count");

  a_normal_keeps_cnt: assert property (@(posedge clk) disable iff (rst)
    ctrl.accept && !ctrl.cal |=> cnt == $past(cnt))
    else $error("normal item changed the calibration count");

  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    ctrl.accept && done |=> cnt == '0 && sums[0] == '0 && sums[imubc_pkg::AXIS_GYRO_Z] == '0)
    else $error("closing calibration item did not clear the sums");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/imu_bias_calibrate_and_correct_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake      Payload
// sample   in   valid / ready  req_type, raw_accel_x/y/z, raw_gyro_x/y/z
// result   out  valid / ready  accel_x/y/z_g, gyro_x/y/z_dps, cal_done
//
// One item per cycle while result.ready stays high; a result passes through five
// register stages (input, offset subtract, gyro multiply, scale, output).
// The closing calibration item writes new offsets as it leaves the second stage,
// in time for the item right behind it.
// Reset clears the stage valids, sums, count and offsets; sample.ready is low during it
// and high after it.
// A held result stalls only the full stages behind it; empty stages keep taking items.

module imu_bias_calibrate_and_correct_core #(
  parameter int NUM_CAL_SAMPLES = 40
) (
  input  logic             clk,
  input  logic             rst,
  imubc_sample_if.sink     sample,
  imubc_result_if.source   result
);

  imubc_pkg::ctrl_t   ctrl;
  logic               accept;
  logic               done_now;
  logic               valid_a, valid_b, valid_c, valid_d, valid_o;
  logic               adv_a, adv_b, adv_c, adv_d;
  logic               free_a, free_b, free_c, free_d, free_o;

  imubc_pkg::raw_t    raw_in   [imubc_pkg::NAXES];
  imubc_pkg::off_t    offsets  [imubc_pkg::NAXES];

  logic               cal_a, done_a;
  imubc_pkg::raw_t    raw_a    [imubc_pkg::NAXES];
  logic               cal_b, done_b;
  imubc_pkg::raw_t    raw_b    [imubc_pkg::NAXES];
  imubc_pkg::diff_t   diff_next[imubc_pkg::NAXES];
  logic               done_c;
  imubc_pkg::diff_t   diff_c   [imubc_pkg::NAXES];
  logic [imubc_pkg::ACC_W-1:0]       gmag_c  [imubc_pkg::NGYRO];
  logic                              done_d;
  imubc_pkg::diff_t                  acc_d   [imubc_pkg::NGYRO];
  logic [imubc_pkg::GYRO_PROD_W-1:0] gprod_d [imubc_pkg::NGYRO];
  logic                              gsign_d [imubc_pkg::NGYRO];
  logic [imubc_pkg::GYR_W-1:0]       gq_d    [imubc_pkg::NGYRO];
  imubc_pkg::gyro_t                  gyro_next [imubc_pkg::NGYRO];
  imubc_pkg::diff_t                  acc_o   [imubc_pkg::NGYRO];
  imubc_pkg::gyro_t                  gyro_o  [imubc_pkg::NGYRO];
  logic                              done_o;

  // stage flow: a stage moves on when the one ahead is empty or moving
  always_comb begin
    free_o = !valid_o || result.ready;
    adv_d  = valid_d && free_o;
    free_d = !valid_d || free_o;
    adv_c  = valid_c && free_d;
    free_c = !valid_c || free_d;
    adv_b  = valid_b && free_c;
    free_b = !valid_b || free_c;
    adv_a  = valid_a && free_b;
    free_a = !valid_a || free_b;
    accept = sample.valid && free_a && !rst;
  end

  // hold off the sender while in reset
  assign sample.ready = free_a && !rst;

  always_comb begin
    raw_in[imubc_pkg::AXIS_ACCEL_X] = sample.raw_accel_x;
    raw_in[imubc_pkg::AXIS_ACCEL_Y] = sample.raw_accel_y;
    raw_in[imubc_pkg::AXIS_ACCEL_Z] = sample.raw_accel_z;
    raw_in[imubc_pkg::AXIS_GYRO_X]  = sample.raw_gyro_x;
    raw_in[imubc_pkg::AXIS_GYRO_Y]  = sample.raw_gyro_y;
    raw_in[imubc_pkg::AXIS_GYRO_Z]  = sample.raw_gyro_z;

    ctrl.accept = accept;
    ctrl.cal    = sample.req_type;
    ctrl.adv_a  = adv_a;
    ctrl.adv_b  = adv_b;
    ctrl.done_b = done_b;
  end

  imubc_offset_calc #(
    .NUM_CAL_SAMPLES (NUM_CAL_SAMPLES)
  ) u_offset_calc (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .raw     (raw_in),
    .done    (done_now),
    .offsets (offsets)
  );

  always_comb begin
    // calibration items pass uncorrected
    for (int i = 0; i < imubc_pkg::NAXES; i++) begin
      diff_next[i] = {raw_b[i][imubc_pkg::RAW_W-1], raw_b[i], {imubc_pkg::FRAC_SHIFT{1'b0}}}
                   - (cal_b ? imubc_pkg::ACC_W'(0)
                            : {offsets[i][imubc_pkg::OFF_W-1], offsets[i]});
    end
    for (int j = 0; j < imubc_pkg::NGYRO; j++) begin
      gmag_c[j]    = diff_c[imubc_pkg::AXIS_GYRO_X + j][imubc_pkg::ACC_W-1]
                   ? ($unsigned(~diff_c[imubc_pkg::AXIS_GYRO_X + j]) + imubc_pkg::ACC_W'(1))
                   : $unsigned(diff_c[imubc_pkg::AXIS_GYRO_X + j]);
      gq_d[j]      = gprod_d[j][imubc_pkg::GYRO_SHIFT +: imubc_pkg::GYR_W];
      gyro_next[j] = gsign_d[j] ? $signed(~gq_d[j] + imubc_pkg::GYR_W'(1)) : $signed(gq_d[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
      valid_c <= 1'b0;
      valid_d <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      valid_a <= accept || (valid_a && !adv_a);
      valid_b <= adv_a  || (valid_b && !adv_b);
      valid_c <= adv_b  || (valid_c && !adv_c);
      valid_d <= adv_c  || (valid_d && !adv_d);
      valid_o <= adv_d  || (valid_o && !result.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cal_a  <= sample.req_type;
      done_a <= done_now;
      raw_a  <= raw_in;
    end
    if (adv_a) begin
      cal_b  <= cal_a;
      done_b <= done_a;
      raw_b  <= raw_a;
    end
    if (adv_b) begin
      done_c <= done_b;
      diff_c <= diff_next;
    end
    if (adv_c) begin
      done_d <= done_c;
      for (int j = 0; j < imubc_pkg::NGYRO; j++) begin
        acc_d[j]   <= diff_c[imubc_pkg::AXIS_ACCEL_X + j];
        gprod_d[j] <= imubc_pkg::GYRO_PROD_W'(gmag_c[j])
                    * imubc_pkg::GYRO_PROD_W'(imubc_pkg::GYRO_RECIP);
        gsign_d[j] <= diff_c[imubc_pkg::AXIS_GYRO_X + j][imubc_pkg::ACC_W-1];
      end
    end
    if (adv_d) begin
      done_o <= done_d;
      acc_o  <= acc_d;
      gyro_o <= gyro_next;
    end
  end

  assign result.valid      = valid_o;
  assign result.accel_x_g  = acc_o[0];
  assign result.accel_y_g  = acc_o[1];
  assign result.accel_z_g  = acc_o[2];
  assign result.gyro_x_dps = gyro_o[0];
  assign result.gyro_y_dps = gyro_o[1];
  assign result.gyro_z_dps = gyro_o[2];
  assign result.cal_done   = done_o;

`ifndef SYNTHESIS
  a_done_is_cal: assert property (@(posedge clk) disable iff (rst)
    valid_b && done_b |-> cal_b)
    else $error("closing flag on a normal item");

  a_done_follows_item: assert property (@(posedge clk) disable iff (rst)
    adv_b && done_b |=> valid_c && done_c)
    else $error("closing flag lost past the offset write");

  a_cal_uncorrected: assert property (@(posedge clk) disable iff (rst)
    valid_d && done_d |-> acc_d[0][imubc_pkg::FRAC_SHIFT-1:0] == '0
                       && acc_d[1][imubc_pkg::FRAC_SHIFT-1:0] == '0
                       && acc_d[2][imubc_pkg::FRAC_SHIFT-1:0] == '0)
    else $error("closing calibration item was offset corrected");
`endif

endmodule

`default_nettype wire
